@@ rtl/cgh_pkg.sv @@
// Shared types and constants for the CGA and Hercules video port block.
// No dependencies; imported by every module of the block.
package cgh_pkg;

  // Default number of CRTC registers kept per adapter.
  localparam int CRTC_REG_COUNT_DEF = 16;

  // I/O port numbers.
  localparam logic [9:0] PORT_CGA_INDEX  = 10'h3d4;
  localparam logic [9:0] PORT_CGA_DATA   = 10'h3d5;
  localparam logic [9:0] PORT_CGA_MODE   = 10'h3d8;
  localparam logic [9:0] PORT_CGA_COLOR  = 10'h3d9;
  localparam logic [9:0] PORT_CGA_STATUS = 10'h3da;
  localparam logic [9:0] PORT_HGC_INDEX  = 10'h3b4;
  localparam logic [9:0] PORT_HGC_DATA   = 10'h3b5;
  localparam logic [9:0] PORT_HGC_MODE   = 10'h3b8;
  localparam logic [9:0] PORT_HGC_STATUS = 10'h3ba;
  localparam logic [9:0] PORT_HGC_SWITCH = 10'h3bf;

  // CRTC register numbers that carry display settings.
  localparam int CRTC_CUR_START = 10;
  localparam int CRTC_CUR_END   = 11;
  localparam int CRTC_START_HI  = 12;
  localparam int CRTC_START_LO  = 13;
  localparam int CRTC_CUR_HI    = 14;
  localparam int CRTC_CUR_LO    = 15;

  // Display mode codes.
  localparam logic [2:0] MODE_TEXT40  = 3'd0;
  localparam logic [2:0] MODE_TEXT80  = 3'd1;
  localparam logic [2:0] MODE_CGA320  = 3'd2;
  localparam logic [2:0] MODE_CGA640  = 3'd3;
  localparam logic [2:0] MODE_HGC720  = 3'd4;

  // Read values.
  localparam logic [7:0] RD_UNMAPPED   = 8'hff;
  localparam logic [7:0] RD_ZERO       = 8'h00;
  localparam logic [7:0] RD_CGA_STATUS = 8'h09;
  localparam logic [7:0] RD_HGC_STATUS = 8'h80;

  // Video memory offsets.
  localparam logic [17:0] CGA_FRAME_BASE = 18'h08000;
  localparam logic [17:0] HGC_PAGE1_BASE = 18'h08000;

  // Reciprocal of 5: floor(x * DIV5_MUL / 2^DIV5_SHIFT) == x / 5 for x below 2^14.
  localparam logic [11:0] DIV5_MUL   = 12'd3277;
  localparam int          DIV5_SHIFT = 14;

  typedef struct packed {
    logic        video_enabled;
    logic [2:0]  display_mode;
    logic [17:0] frame_offset;
    logic        blink_enable;
    logic [1:0]  palette_index;
    logic [3:0]  color_index;
    logic        cursor_visible;
    logic [5:0]  cursor_start;
    logic [5:0]  cursor_end;
    logic [10:0] cursor_row;
    logic [6:0]  cursor_col;
  } settings_t;

endpackage

@@ rtl/cgh_cursor_pos.sv @@
// Splits a 16-bit CRTC cursor address into text row and column.
// Depends on cgh_pkg for the reciprocal constants.
module cgh_cursor_pos import cgh_pkg::*; (
  input  logic [15:0] pos,
  input  logic        text40,
  output logic [10:0] row,
  output logic [6:0]  col
);

  logic [12:0] scaled;
  logic [24:0] prod;
  logic [10:0] quot;
  logic [17:0] quot_cols;
  logic [17:0] diff;

  // Dividing by 40 or 80 is a shift by 3 or 4 followed by a divide by 5.
  always_comb begin
    scaled    = text40 ? pos[15:3] : {1'b0, pos[15:4]};
    prod      = {12'b0, scaled} * {13'b0, DIV5_MUL};
    quot      = prod[DIV5_SHIFT +: 11];
    quot_cols = text40 ? ({2'b0, quot, 5'b0} + {4'b0, quot, 3'b0})
                       : ({1'b0, quot, 6'b0} + {3'b0, quot, 4'b0});
    diff      = {2'b0, pos} - quot_cols;
    row       = quot;
    col       = diff[6:0];
  end

endmodule

@@ rtl/cga_hercules_video_ports.sv @@
// CGA and Hercules 6845 CRTC port block: register files, mode registers and
// the display settings derived from them. Depends on cgh_pkg and cgh_cursor_pos.
//
// A transfer is captured in the input register and its result is registered in the output
// register once the decode stage advances.
// Throughput: one port access per cycle while the output side is not stalled; the single
// decode-and-update pass between the input and output registers sets that figure. Reset
// (rst_n low, synchronous) clears both CRTC files, the index, mode, color and switch registers,
// the status counters and all display settings, and empties both pipeline registers.
module cga_hercules_video_ports import cgh_pkg::*; #(
  parameter int CRTC_REG_COUNT = CRTC_REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [9:0]  in_port_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_video_enabled,
  output logic [2:0]  out_display_mode,
  output logic [17:0] out_frame_offset,
  output logic        out_blink_enable,
  output logic [1:0]  out_palette_index,
  output logic [3:0]  out_color_index,
  output logic        out_cursor_visible,
  output logic [5:0]  out_cursor_start,
  output logic [5:0]  out_cursor_end,
  output logic [10:0] out_cursor_row,
  output logic [6:0]  out_cursor_col
);

  localparam int IDX_W = $clog2(CRTC_REG_COUNT);

  // Input register: one port access waiting to be decoded.
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [9:0] s1_port_r;
  logic [7:0] s1_data_r;

  // Architectural state.
  logic [7:0] cga_file_r [CRTC_REG_COUNT];
  logic [7:0] hgc_file_r [CRTC_REG_COUNT];
  logic [7:0] cga_index_r, cga_index_nxt;
  logic [7:0] hgc_index_r, hgc_index_nxt;
  logic [7:0] cga_mode_r, cga_mode_nxt;
  logic [7:0] cga_color_r, cga_color_nxt;
  logic [7:0] hgc_mode_r, hgc_mode_nxt;
  logic [7:0] hgc_switch_r, hgc_switch_nxt;
  logic [2:0] cga_query_r, cga_query_nxt;
  logic [2:0] hgc_query_r, hgc_query_nxt;
  settings_t  set_r, set_nxt;

  // Output register.
  logic       out_valid_r;
  logic [7:0] rd_r, rd_nxt;
  settings_t  out_set_r;

  logic advance;

  // The decode stage moves its item on whenever the output register is empty or
  // being drained in this cycle; the input register refills behind it.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  // Decode of the held access.
  logic       cga_crtc_wr, hgc_crtc_wr, crtc_wr;
  logic [7:0] crtc_idx;
  logic [7:0] r10, r11, r12, r13, r14, r15;
  logic [4:0] cs_lines, ce_lines;
  logic       do_cga, do_hgc;
  logic [10:0] pos_row;
  logic [6:0]  pos_col;

  always_comb begin
    cga_crtc_wr = s1_mode_r && (s1_port_r == PORT_CGA_DATA) &&
                  (cga_index_r < 8'(CRTC_REG_COUNT));
    hgc_crtc_wr = s1_mode_r && (s1_port_r == PORT_HGC_DATA) &&
                  (hgc_index_r < 8'(CRTC_REG_COUNT));
    crtc_wr  = cga_crtc_wr || hgc_crtc_wr;
    crtc_idx = cga_crtc_wr ? cga_index_r : hgc_index_r;

    // Settings registers of the adapter addressed, as they stand after this write.
    if (cga_crtc_wr) begin
      r10 = cga_file_r[CRTC_CUR_START];
      r11 = cga_file_r[CRTC_CUR_END];
      r12 = cga_file_r[CRTC_START_HI];
      r13 = cga_file_r[CRTC_START_LO];
      r14 = cga_file_r[CRTC_CUR_HI];
      r15 = cga_file_r[CRTC_CUR_LO];
    end else begin
      r10 = hgc_file_r[CRTC_CUR_START];
      r11 = hgc_file_r[CRTC_CUR_END];
      r12 = hgc_file_r[CRTC_START_HI];
      r13 = hgc_file_r[CRTC_START_LO];
      r14 = hgc_file_r[CRTC_CUR_HI];
      r15 = hgc_file_r[CRTC_CUR_LO];
    end
    if (crtc_idx == 8'(CRTC_CUR_START)) r10 = s1_data_r;
    if (crtc_idx == 8'(CRTC_CUR_END))   r11 = s1_data_r;
    if (crtc_idx == 8'(CRTC_START_HI))  r12 = s1_data_r;
    if (crtc_idx == 8'(CRTC_START_LO))  r13 = s1_data_r;
    if (crtc_idx == 8'(CRTC_CUR_HI))    r14 = s1_data_r;
    if (crtc_idx == 8'(CRTC_CUR_LO))    r15 = s1_data_r;
    // The frame start of the CGA always comes from its own file.
    if (!cga_crtc_wr) begin
      r12 = cga_file_r[CRTC_START_HI];
      r13 = cga_file_r[CRTC_START_LO];
    end
    cs_lines = r10[4:0];
    ce_lines = r11[4:0];
  end

  cgh_cursor_pos u_cursor_pos (
    .pos    ({r14, r15}),
    .text40 (set_r.display_mode == MODE_TEXT40),
    .row    (pos_row),
    .col    (pos_col)
  );

  always_comb begin
    cga_index_nxt  = cga_index_r;
    hgc_index_nxt  = hgc_index_r;
    cga_mode_nxt   = cga_mode_r;
    cga_color_nxt  = cga_color_r;
    hgc_mode_nxt   = hgc_mode_r;
    hgc_switch_nxt = hgc_switch_r;
    cga_query_nxt  = cga_query_r;
    hgc_query_nxt  = hgc_query_r;
    set_nxt        = set_r;
    rd_nxt         = RD_UNMAPPED;
    do_cga         = 1'b0;
    do_hgc         = 1'b0;

    if (s1_mode_r) begin
      unique case (s1_port_r)
        PORT_CGA_INDEX:  cga_index_nxt = s1_data_r;
        PORT_CGA_MODE: begin
          cga_mode_nxt = s1_data_r;
          do_cga       = 1'b1;
        end
        PORT_CGA_COLOR: begin
          cga_color_nxt = s1_data_r;
          do_cga        = 1'b1;
        end
        PORT_HGC_INDEX:  hgc_index_nxt = s1_data_r;
        PORT_HGC_MODE: begin
          hgc_mode_nxt = s1_data_r;
          do_hgc       = 1'b1;
        end
        PORT_HGC_SWITCH: begin
          hgc_switch_nxt = s1_data_r;
          do_hgc         = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (s1_port_r)
        PORT_CGA_INDEX, PORT_HGC_INDEX: rd_nxt = RD_ZERO;
        PORT_CGA_DATA:
          rd_nxt = (cga_index_r == 8'(CRTC_CUR_HI)) ? cga_file_r[CRTC_CUR_HI] :
                   (cga_index_r == 8'(CRTC_CUR_LO)) ? cga_file_r[CRTC_CUR_LO] : RD_ZERO;
        PORT_HGC_DATA:
          rd_nxt = (hgc_index_r == 8'(CRTC_CUR_HI)) ? hgc_file_r[CRTC_CUR_HI] :
                   (hgc_index_r == 8'(CRTC_CUR_LO)) ? hgc_file_r[CRTC_CUR_LO] : RD_ZERO;
        PORT_CGA_COLOR: rd_nxt = cga_color_r;
        PORT_CGA_STATUS: begin
          cga_query_nxt = cga_query_r + 3'd1;
          rd_nxt        = (cga_query_nxt != 3'd0) ? RD_CGA_STATUS : RD_ZERO;
        end
        PORT_HGC_STATUS: begin
          hgc_query_nxt = hgc_query_r + 3'd1;
          rd_nxt        = (hgc_query_nxt != 3'd0) ? RD_ZERO : RD_HGC_STATUS;
        end
        default: ;
      endcase
    end

    // CRTC data writes update the settings tied to the register written.
    if (crtc_wr) begin
      case (crtc_idx)
        8'(CRTC_CUR_START): begin
          set_nxt.cursor_visible = (r10[7:5] >= 3'd2);
          set_nxt.cursor_start   = cga_crtc_wr ? {cs_lines, 1'b0} : {1'b0, cs_lines};
          set_nxt.cursor_end     = cga_crtc_wr ? {ce_lines, 1'b0} : {1'b0, ce_lines};
        end
        8'(CRTC_CUR_END): begin
          set_nxt.cursor_start = cga_crtc_wr ? {cs_lines, 1'b0} : {1'b0, cs_lines};
          set_nxt.cursor_end   = cga_crtc_wr ? {ce_lines, 1'b0} : {1'b0, ce_lines};
        end
        8'(CRTC_START_HI), 8'(CRTC_START_LO): begin
          do_cga = cga_crtc_wr;
          do_hgc = hgc_crtc_wr;
        end
        8'(CRTC_CUR_HI), 8'(CRTC_CUR_LO): begin
          set_nxt.cursor_row = pos_row;
          set_nxt.cursor_col = pos_col;
        end
        default: ;
      endcase
    end

    // Mode application. With video disabled only the enable bit changes.
    if (do_cga) begin
      if (!cga_mode_nxt[3]) begin
        set_nxt.video_enabled = 1'b0;
      end else begin
        set_nxt.frame_offset = {1'b0, r12, r13, 1'b0} + CGA_FRAME_BASE;
        if (!cga_mode_nxt[1]) begin
          set_nxt.display_mode = cga_mode_nxt[0] ? MODE_TEXT80 : MODE_TEXT40;
          set_nxt.blink_enable = cga_mode_nxt[5];
        end else if (!cga_mode_nxt[4]) begin
          set_nxt.display_mode  = MODE_CGA320;
          set_nxt.palette_index = cga_color_nxt[5:4];
          set_nxt.color_index   = cga_color_nxt[3:0];
        end else begin
          set_nxt.display_mode = MODE_CGA640;
          set_nxt.color_index  = cga_color_nxt[3:0];
        end
        set_nxt.video_enabled = 1'b1;
      end
    end

    // Hercules graphics needs the allow-graphics switch; page 1 needs its own switch.
    if (do_hgc) begin
      if (!hgc_mode_nxt[3]) begin
        set_nxt.video_enabled = 1'b0;
      end else begin
        if (!hgc_mode_nxt[1] || !hgc_switch_nxt[0]) begin
          set_nxt.frame_offset = '0;
          set_nxt.display_mode = MODE_TEXT80;
          set_nxt.blink_enable = hgc_mode_nxt[5];
        end else begin
          set_nxt.frame_offset = (hgc_mode_nxt[7] && hgc_switch_nxt[1]) ? HGC_PAGE1_BASE
                                                                        : '0;
          set_nxt.display_mode = MODE_HGC720;
        end
        set_nxt.video_enabled = 1'b1;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s1_mode_r <= in_mode;
      s1_port_r <= in_port_address;
      s1_data_r <= in_write_data;
    end
  end

  // State update, once per decoded access.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CRTC_REG_COUNT; i++) begin
        cga_file_r[i] <= '0;
        hgc_file_r[i] <= '0;
      end
      cga_index_r  <= '0;
      hgc_index_r  <= '0;
      cga_mode_r   <= '0;
      cga_color_r  <= '0;
      hgc_mode_r   <= '0;
      hgc_switch_r <= '0;
      cga_query_r  <= '0;
      hgc_query_r  <= '0;
      set_r        <= '0;
    end else if (advance) begin
      if (cga_crtc_wr) cga_file_r[cga_index_r[IDX_W-1:0]] <= s1_data_r;
      if (hgc_crtc_wr) hgc_file_r[hgc_index_r[IDX_W-1:0]] <= s1_data_r;
      cga_index_r  <= cga_index_nxt;
      hgc_index_r  <= hgc_index_nxt;
      cga_mode_r   <= cga_mode_nxt;
      cga_color_r  <= cga_color_nxt;
      hgc_mode_r   <= hgc_mode_nxt;
      hgc_switch_r <= hgc_switch_nxt;
      cga_query_r  <= cga_query_nxt;
      hgc_query_r  <= hgc_query_nxt;
      set_r        <= set_nxt;
    end
  end

  // Output register: read data and the settings in force after the access.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      rd_r      <= rd_nxt;
      out_set_r <= set_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = rd_r;
  assign out_video_enabled  = out_set_r.video_enabled;
  assign out_display_mode   = out_set_r.display_mode;
  assign out_frame_offset   = out_set_r.frame_offset;
  assign out_blink_enable   = out_set_r.blink_enable;
  assign out_palette_index  = out_set_r.palette_index;
  assign out_color_index    = out_set_r.color_index;
  assign out_cursor_visible = out_set_r.cursor_visible;
  assign out_cursor_start   = out_set_r.cursor_start;
  assign out_cursor_end     = out_set_r.cursor_end;
  assign out_cursor_row     = out_set_r.cursor_row;
  assign out_cursor_col     = out_set_r.cursor_col;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the CGA and Hercules video port block.
// Depends on cgh_pkg and the RTL of cga_hercules_video_ports; reads no files.
// A queue-fed driver offers port accesses, and a monitor checks every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cgh_pkg::*;

  // Adapter selectors for the duplicated CRTC state.
  localparam int ADP_CGA = 0;
  localparam int ADP_HGC = 1;

  // Direction of a port access, as carried on in_mode.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Characters per text row, which is used to split the cursor address.
  localparam int TEXT40_COLS = 40;
  localparam int TEXT80_COLS = 80;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LINES = 200;

  typedef struct packed {
    logic       mode;
    logic [9:0] port;
    logic [7:0] data;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    settings_t  view;
  } port_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = ACC_READ;
  logic [9:0]  in_port_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_video_enabled;
  logic [2:0]  out_display_mode;
  logic [17:0] out_frame_offset;
  logic        out_blink_enable;
  logic [1:0]  out_palette_index;
  logic [3:0]  out_color_index;
  logic        out_cursor_visible;
  logic [5:0]  out_cursor_start;
  logic [5:0]  out_cursor_end;
  logic [10:0] out_cursor_row;
  logic [6:0]  out_cursor_col;

  cga_hercules_video_ports uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_port_address    (in_port_address),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_video_enabled  (out_video_enabled),
    .out_display_mode   (out_display_mode),
    .out_frame_offset   (out_frame_offset),
    .out_blink_enable   (out_blink_enable),
    .out_palette_index  (out_palette_index),
    .out_color_index    (out_color_index),
    .out_cursor_visible (out_cursor_visible),
    .out_cursor_start   (out_cursor_start),
    .out_cursor_end     (out_cursor_end),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block's registers. These mirror what the block should
  // hold after every accepted transfer and, once set up at the start, are only touched by the monitor.
  // ---------------------------------------------------------------------------
  logic [7:0] crtc_file [2][CRTC_REG_COUNT_DEF];
  logic [7:0] crtc_index [2];
  logic [2:0] status_count [2];
  logic [7:0] cga_mode_reg;
  logic [7:0] cga_color_reg;
  logic [7:0] hgc_mode_reg;
  logic [7:0] hgc_switch_reg;
  settings_t  live;

  // Transfers waiting to be offered, and results waiting to come back.
  bus_access_t  access_q[$];
  port_result_t expected_q[$];

  int  queued_total = 0;
  int  checked_total = 0;
  int  fail_count = 0;
  int  report_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  burst_req = 0;
  int  burst_ack = 0;
  int  burst_left = 0;
  logic in_took = 1'b0;

  // CGA mode register: bit 3 enables video, bit 1 selects graphics, bit 4
  // selects 640-wide graphics, bit 0 selects 80 columns and bit 5 blink.
  // A disabling write only drops video_enabled and leaves the rest alone.
  function automatic void refresh_cga();
    logic [15:0] start_addr;
    start_addr = {crtc_file[ADP_CGA][CRTC_START_HI], crtc_file[ADP_CGA][CRTC_START_LO]};
    if (!cga_mode_reg[3]) begin
      live.video_enabled = 1'b0;
      return;
    end
    live.frame_offset = CGA_FRAME_BASE + {1'b0, start_addr, 1'b0};
    if (!cga_mode_reg[1]) begin
      live.display_mode = cga_mode_reg[0] ? MODE_TEXT80 : MODE_TEXT40;
      live.blink_enable = cga_mode_reg[5];
    end else if (!cga_mode_reg[4]) begin
      live.display_mode = MODE_CGA320;
      live.palette_index = {cga_color_reg[5], cga_color_reg[4]};
      live.color_index = cga_color_reg[3:0];
    end else begin
      live.display_mode = MODE_CGA640;
      live.color_index = cga_color_reg[3:0];
    end
    live.video_enabled = 1'b1;
  endfunction

  // Hercules graphics needs both the graphics bit of the mode register and
  // the allow-graphics switch; page 1 needs the page bit and its switch.
  function automatic void refresh_hgc();
    if (!hgc_mode_reg[3]) begin
      live.video_enabled = 1'b0;
      return;
    end
    if (!hgc_mode_reg[1] || !hgc_switch_reg[0]) begin
      live.frame_offset = '0;
      live.display_mode = MODE_TEXT80;
      live.blink_enable = hgc_mode_reg[5];
    end else begin
      live.frame_offset = (hgc_mode_reg[7] && hgc_switch_reg[1]) ? HGC_PAGE1_BASE : '0;
      live.display_mode = MODE_HGC720;
    end
    live.video_enabled = 1'b1;
  endfunction

  // CGA scanlines are doubled, Hercules ones are taken as they are.
  function automatic logic [5:0] scanline(int adp, logic [7:0] reg_val);
    return (adp == ADP_CGA) ? {reg_val[4:0], 1'b0} : {1'b0, reg_val[4:0]};
  endfunction

  function automatic void write_crtc(int adp, logic [7:0] value);
    logic [7:0]  sel;
    logic [15:0] pos;
    int unsigned cols;
    sel = crtc_index[adp];
    // Indexes past the register file are dropped without any effect.
    if (sel >= CRTC_REG_COUNT_DEF) return;
    crtc_file[adp][sel] = value;
    case (sel)
      CRTC_CUR_START: begin
        live.cursor_visible = (crtc_file[adp][CRTC_CUR_START][7:5] >= 3'd2);
        live.cursor_start = scanline(adp, crtc_file[adp][CRTC_CUR_START]);
        live.cursor_end = scanline(adp, crtc_file[adp][CRTC_CUR_END]);
      end
      CRTC_CUR_END: begin
        live.cursor_start = scanline(adp, crtc_file[adp][CRTC_CUR_START]);
        live.cursor_end = scanline(adp, crtc_file[adp][CRTC_CUR_END]);
      end
      CRTC_START_HI, CRTC_START_LO: begin
        if (adp == ADP_CGA) refresh_cga();
        else refresh_hgc();
      end
      CRTC_CUR_HI, CRTC_CUR_LO: begin
        // The split uses whatever display mode is in force at this write.
        pos = {crtc_file[adp][CRTC_CUR_HI], crtc_file[adp][CRTC_CUR_LO]};
        cols = (live.display_mode == MODE_TEXT40) ? TEXT40_COLS : TEXT80_COLS;
        live.cursor_row = 11'(pos / cols);
        live.cursor_col = 7'(pos % cols);
      end
      default: ;
    endcase
  endfunction

  // Only the cursor address registers of the CRTC read back.
  function automatic logic [7:0] read_crtc(int adp);
    logic [7:0] sel;
    sel = crtc_index[adp];
    return (sel == CRTC_CUR_HI || sel == CRTC_CUR_LO) ? crtc_file[adp][sel] : RD_ZERO;
  endfunction

  // Applies one port access to the shadow state and returns the result the
  // block should give for it: read data plus the settings after the access.
  function automatic port_result_t apply_port_access(bus_access_t acc);
    port_result_t res;
    res.read_data = RD_UNMAPPED;
    if (acc.mode == ACC_WRITE) begin
      case (acc.port)
        PORT_CGA_INDEX:  crtc_index[ADP_CGA] = acc.data;
        PORT_CGA_DATA:   write_crtc(ADP_CGA, acc.data);
        PORT_CGA_MODE:   begin cga_mode_reg = acc.data; refresh_cga(); end
        PORT_CGA_COLOR:  begin cga_color_reg = acc.data; refresh_cga(); end
        PORT_HGC_INDEX:  crtc_index[ADP_HGC] = acc.data;
        PORT_HGC_DATA:   write_crtc(ADP_HGC, acc.data);
        PORT_HGC_MODE:   begin hgc_mode_reg = acc.data; refresh_hgc(); end
        PORT_HGC_SWITCH: begin hgc_switch_reg = acc.data; refresh_hgc(); end
        default: ;
      endcase
    end else begin
      case (acc.port)
        PORT_CGA_INDEX, PORT_HGC_INDEX: res.read_data = RD_ZERO;
        PORT_CGA_DATA:  res.read_data = read_crtc(ADP_CGA);
        PORT_HGC_DATA:  res.read_data = read_crtc(ADP_HGC);
        PORT_CGA_COLOR: res.read_data = cga_color_reg;
        // Status counters step before they are tested and wrap in 3 bits.
        PORT_CGA_STATUS: begin
          status_count[ADP_CGA] = status_count[ADP_CGA] + 3'd1;
          res.read_data = (status_count[ADP_CGA] != 3'd0) ? RD_CGA_STATUS : RD_ZERO;
        end
        PORT_HGC_STATUS: begin
          status_count[ADP_HGC] = status_count[ADP_HGC] + 3'd1;
          res.read_data = (status_count[ADP_HGC] != 3'd0) ? RD_ZERO : RD_HGC_STATUS;
        end
        default: ;
      endcase
    end
    res.view = live;
    return res;
  endfunction

  task automatic compare_field(string name, logic [17:0] want, logic [17:0] got);
    if (got !== want) begin
      fail_count++;
      report_count++;
      if (report_count <= REPORT_LINES)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock; the single reset pulse at the start of the run comes from the test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. At each falling edge it either holds the current transfer (still
  // stalled), or moves to the next pending access unless it rolls an idle
  // cycle. Valid is decided without looking at stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bus_access_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = access_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= nxt.mode;
        in_port_address <= nxt.port;
        in_write_data <= nxt.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off. Each new request starts a fixed stretch during
  // which the result side stays stalled, so the block backs up and has to
  // push back on its input while the driver keeps offering transfers.
  always @(negedge clk) begin
    if (burst_req != burst_ack) begin
      burst_left <= HOLD_CYCLES;
      burst_ack <= burst_req;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
    end
  end

  // Result-side stall: the hold-off above, or a random stall per cycle.
  always @(negedge clk) begin
    out_stall <= (burst_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge it first checks a result transfer against the
  // oldest expectation, then predicts the result of an input transfer taken
  // at the same edge. The result of this edge's input can not come out at the
  // same edge, so this order keeps the matching exact.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    port_result_t got;
    port_result_t want;
    bus_access_t  acc;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.read_data = out_read_data;
        got.view.video_enabled = out_video_enabled;
        got.view.display_mode = out_display_mode;
        got.view.frame_offset = out_frame_offset;
        got.view.blink_enable = out_blink_enable;
        got.view.palette_index = out_palette_index;
        got.view.color_index = out_color_index;
        got.view.cursor_visible = out_cursor_visible;
        got.view.cursor_start = out_cursor_start;
        got.view.cursor_end = out_cursor_end;
        got.view.cursor_row = out_cursor_row;
        got.view.cursor_col = out_cursor_col;
        if (expected_q.size() == 0) begin
          fail_count++;
          report_count++;
          if (report_count <= REPORT_LINES)
            $display("%0t: result transfer with nothing expected, expected none, actual %0h",
                     $time, got);
        end else begin
          want = expected_q.pop_front();
          compare_field("read_data", 18'(want.read_data), 18'(got.read_data));
          compare_field("video_enabled", 18'(want.view.video_enabled),
                        18'(got.view.video_enabled));
          compare_field("display_mode", 18'(want.view.display_mode),
                        18'(got.view.display_mode));
          compare_field("frame_offset", want.view.frame_offset, got.view.frame_offset);
          compare_field("blink_enable", 18'(want.view.blink_enable),
                        18'(got.view.blink_enable));
          compare_field("palette_index", 18'(want.view.palette_index),
                        18'(got.view.palette_index));
          compare_field("color_index", 18'(want.view.color_index),
                        18'(got.view.color_index));
          compare_field("cursor_visible", 18'(want.view.cursor_visible),
                        18'(got.view.cursor_visible));
          compare_field("cursor_start", 18'(want.view.cursor_start),
                        18'(got.view.cursor_start));
          compare_field("cursor_end", 18'(want.view.cursor_end),
                        18'(got.view.cursor_end));
          compare_field("cursor_row", 18'(want.view.cursor_row),
                        18'(got.view.cursor_row));
          compare_field("cursor_col", 18'(want.view.cursor_col),
                        18'(got.view.cursor_col));
          checked_total <= checked_total + 1;
        end
      end
      if (in_valid && !in_stall) begin
        acc.mode = in_mode;
        acc.port = in_port_address;
        acc.data = in_write_data;
        expected_q.push_back(apply_port_access(acc));
      end
      in_took <= in_valid && !in_stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Accesses are queued at a rising edge, where the driver
  // never touches the queue.
  // ---------------------------------------------------------------------------
  task automatic push_access(logic mode, logic [9:0] port, logic [7:0] data);
    bus_access_t acc;
    acc.mode = mode;
    acc.port = port;
    acc.data = data;
    access_q.push_back(acc);
    queued_total++;
  endtask

  function automatic logic [9:0] pick_mapped_port();
    case ($urandom_range(9))
      0: return PORT_CGA_INDEX;
      1: return PORT_CGA_DATA;
      2: return PORT_CGA_MODE;
      3: return PORT_CGA_COLOR;
      4: return PORT_CGA_STATUS;
      5: return PORT_HGC_INDEX;
      6: return PORT_HGC_DATA;
      7: return PORT_HGC_MODE;
      8: return PORT_HGC_STATUS;
      default: return PORT_HGC_SWITCH;
    endcase
  endfunction

  // Mostly well-formed register traffic with random content: CRTC index and
  // data pairs, mode/color/switch writes that usually keep video on, status
  // polls long enough to wrap the counters, and some raw bus noise.
  task automatic queue_random_accesses(int count);
    int         goal;
    int         kind;
    int         polls;
    logic [7:0] sel;
    logic [7:0] data;
    logic [9:0] port;
    logic       hgc;
    goal = queued_total + count;
    while (queued_total < goal) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        hgc = 1'($urandom_range(1));
        case ($urandom_range(9))
          0: sel = 8'($urandom_range(255));
          1, 2, 3: sel = 8'($urandom_range(17));
          default: sel = 8'($urandom_range(CRTC_CUR_START, CRTC_CUR_LO));
        endcase
        push_access(ACC_WRITE, hgc ? PORT_HGC_INDEX : PORT_CGA_INDEX, sel);
        push_access(ACC_WRITE, hgc ? PORT_HGC_DATA : PORT_CGA_DATA,
                    8'($urandom_range(255)));
        if ($urandom_range(3) == 0)
          push_access(ACC_READ, hgc ? PORT_HGC_DATA : PORT_CGA_DATA,
                      8'($urandom_range(255)));
      end else if (kind < 55) begin
        data = 8'($urandom_range(255));
        case ($urandom_range(3))
          0: port = PORT_CGA_MODE;
          1: port = PORT_CGA_COLOR;
          2: port = PORT_HGC_MODE;
          default: port = PORT_HGC_SWITCH;
        endcase
        // Keep the video-enable bit set most of the time so the mode
        // decoding below it gets exercised.
        if ($urandom_range(4) != 0) data[3] = 1'b1;
        push_access(ACC_WRITE, port, data);
      end else if (kind < 65) begin
        polls = $urandom_range(1, 10);
        port = $urandom_range(1) ? PORT_HGC_STATUS : PORT_CGA_STATUS;
        repeat (polls) push_access(ACC_READ, port, 8'($urandom_range(255)));
      end else if (kind < 80) begin
        push_access(ACC_READ, pick_mapped_port(), 8'($urandom_range(255)));
      end else begin
        // Raw noise, half of it close to the adapter port ranges.
        port = $urandom_range(1) ? 10'($urandom_range(10'h3b0, 10'h3df))
                                 : 10'($urandom_range(1023));
        push_access(1'($urandom_range(1)), port, 8'($urandom_range(255)));
      end
    end
  endtask

  // Waits until every queued transfer has come back as a checked result.
  task automatic wait_drained();
    while (checked_total != queued_total) @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stl_pct, int count, bit hold_off);
    @(posedge clk);
    send_idle_pct = idle_pct;
    stall_pct = stl_pct;
    if (hold_off) burst_req++;
    queue_random_accesses(count);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    crtc_file = '{default: '{default: '0}};
    crtc_index = '{default: '0};
    status_count = '{default: '0};
    cga_mode_reg = '0;
    cga_color_reg = '0;
    hgc_mode_reg = '0;
    hgc_switch_reg = '0;
    live = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run without idling.
    @(posedge clk);
    push_access(ACC_READ, 10'h000, 8'h00);            // lowest port, unmapped
    push_access(ACC_WRITE, 10'h3ff, 8'hff);           // highest port, unmapped
    push_access(ACC_READ, PORT_CGA_MODE, 8'h00);      // write-only register
    // Cursor shape at its extremes: visible, both scanlines doubled to 62.
    push_access(ACC_WRITE, PORT_CGA_INDEX, 8'(CRTC_CUR_START));
    push_access(ACC_WRITE, PORT_CGA_DATA, 8'hff);
    push_access(ACC_WRITE, PORT_CGA_INDEX, 8'(CRTC_CUR_END));
    push_access(ACC_WRITE, PORT_CGA_DATA, 8'hff);
    // Largest cursor address while still in 40-column text.
    push_access(ACC_WRITE, PORT_CGA_INDEX, 8'(CRTC_CUR_HI));
    push_access(ACC_WRITE, PORT_CGA_DATA, 8'hff);
    push_access(ACC_READ, PORT_CGA_DATA, 8'h00);
    push_access(ACC_WRITE, PORT_CGA_INDEX, 8'(CRTC_CUR_LO));
    push_access(ACC_WRITE, PORT_CGA_DATA, 8'hff);
    // The 320, 640 and 80-column CGA modes, then a disabling write that keeps the other settings.
    push_access(ACC_WRITE, PORT_CGA_COLOR, 8'h3f);
    push_access(ACC_WRITE, PORT_CGA_MODE, 8'h0a);
    push_access(ACC_WRITE, PORT_CGA_MODE, 8'h1a);
    push_access(ACC_WRITE, PORT_CGA_MODE, 8'h29);
    push_access(ACC_WRITE, PORT_CGA_MODE, 8'h00);
    // Out-of-range CRTC index: the data write is dropped, reads give zero.
    push_access(ACC_WRITE, PORT_CGA_INDEX, 8'hff);
    push_access(ACC_WRITE, PORT_CGA_DATA, 8'h55);
    push_access(ACC_READ, PORT_CGA_DATA, 8'h00);
    push_access(ACC_READ, PORT_CGA_INDEX, 8'h00);
    // Hercules graphics on page 1, then text with blink.
    push_access(ACC_WRITE, PORT_HGC_SWITCH, 8'h03);
    push_access(ACC_WRITE, PORT_HGC_MODE, 8'h8a);
    push_access(ACC_WRITE, PORT_HGC_MODE, 8'h28);
    push_access(ACC_READ, PORT_HGC_STATUS, 8'h00);
    push_access(ACC_READ, PORT_CGA_STATUS, 8'h00);
    push_access(ACC_READ, PORT_CGA_COLOR, 8'h00);
    wait_drained();

    // Random part under each idling pattern, then the long hold-off.
    run_phase(0, 0, 350, 1'b0);
    run_phase(51, 0, 350, 1'b0);
    run_phase(0, 51, 350, 1'b0);
    run_phase(32, 32, 350, 1'b0);
    run_phase(0, 0, 300, 1'b1);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results still expected, expected none, actual %0d",
               $time, expected_q.size(), expected_q.size());
    end
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cgh_pkg.sv
rtl/cgh_cursor_pos.sv
rtl/cga_hercules_video_ports.sv
verif/testbench.sv
